[hdl/tcpg_pkg.sv]
// Shared types, constants and the cursor colour function of the text cell pixel generator.
`timescale 1ns / 1ps
`default_nettype none

package tcpg_pkg;

    localparam int PIX_BITS   = 5;
    localparam int PIX_COUNT  = 9;
    localparam int PADDR_BITS = 4;

    localparam logic [1:0] REG_FONT_SOURCE  = 2'd0;
    localparam logic [1:0] REG_NARROW_CELLS = 2'd1;
    localparam logic [1:0] REG_BLINK_ENABLE = 2'd2;

    localparam logic [1:0] FONT_ROM    = 2'd0;
    localparam logic [1:0] FONT_RAM4K  = 2'd1;
    localparam logic [1:0] FONT_RAM48K = 2'd2;

    localparam logic [7:0] ATTR_FIELD_MASK = 8'h77;
    localparam logic [7:0] ATTR_REVERSE    = 8'h70;
    localparam logic [4:0] UNDERLINE_LINE  = 5'd13;
    localparam logic [2:0] ATTR_UNDERLINE  = 3'd1;
    localparam logic [2:0] LINE_GFX_TOP    = 3'b110;
    localparam logic [3:0] CELL_WIDE       = 4'd9;
    localparam logic [3:0] CELL_NARROW     = 4'd8;
    localparam logic [3:0] FG_NORMAL       = 4'd7;
    localparam logic [3:0] MAX_FONT        = 4'd11;

    localparam logic [4:0] CURSOR_BLACK  = 5'd16;
    localparam logic [4:0] CURSOR_NORMAL = 5'd7 + 5'd16;
    localparam logic [4:0] CURSOR_BRIGHT = 5'd15 + 5'd16;

    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [7:0] glyph_row;
        logic [4:0] scan_line;
        logic       blink_phase;
        logic       cursor_here;
    } t_in;

    typedef struct packed {
        logic [44:0] pixel_codes;
        logic [3:0]  cell_width;
        logic [3:0]  font_number;
    } t_out;

    typedef struct packed {
        logic [1:0] font_source;
        logic       narrow_cells;
        logic       blink_enable;
    } t_cfg;

    typedef struct packed {
        logic [3:0] fg;
        logic [3:0] bg;
        logic       blank;
        logic       underline;
        logic       line_gfx;
        logic       cursor;
        logic [4:0] cursor_col;
        logic [7:0] glyph;
        logic       narrow;
        logic [3:0] font;
    } t_dec;

    typedef struct packed {
        logic [3:0] fg;
        logic [3:0] bg;
        logic [8:0] bits;
        logic       cursor;
        logic [4:0] cursor_col;
        logic       narrow;
        logic [3:0] font;
    } t_row;

    function automatic logic [4:0] cursor_colour(input logic [7:0] a);
        logic [4:0] c;
        begin
            if (a == 8'h70 || a == 8'hF0 || a == 8'h00 || a == 8'h08 ||
                a == 8'h80 || a == 8'h88) begin
                c = CURSOR_BLACK;
            end else if (a == 8'h78 || a == 8'hF8) begin
                c = CURSOR_NORMAL;
            end else if (a[3]) begin
                c = CURSOR_BRIGHT;
            end else begin
                c = CURSOR_NORMAL;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/tcpg_decode.sv]
// First stage: attribute, font and cursor decoding of one text cell.
`timescale 1ns / 1ps
`default_nettype none

module tcpg_decode (
    input  wire              i_clk,
    input  wire              i_load,
    input  tcpg_pkg::t_in    i_cell,
    input  tcpg_pkg::t_cfg   i_cfg,
    output tcpg_pkg::t_dec   o_dec
);

    tcpg_pkg::t_dec r_dec;
    tcpg_pkg::t_dec n_dec;
    logic [7:0]     attr;

    always_comb begin
        n_dec = '0;
        attr  = i_cell.attribute;
        if (i_cfg.font_source == tcpg_pkg::FONT_RAM48K) begin
            if (i_cell.attribute[3:2] == 2'b11) begin
                n_dec.font = {1'b0, i_cell.attribute[2:0]};
            end else begin
                n_dec.font = i_cell.attribute[3:0];
            end
            attr = {4'b0000, ~i_cell.attribute[7:4]};
        end
        if (i_cfg.blink_enable) begin
            n_dec.blank = attr[7] & i_cell.blink_phase;
            attr[7]     = 1'b0;
        end
        n_dec.fg = tcpg_pkg::FG_NORMAL;
        n_dec.bg = 4'd0;
        if ((attr & tcpg_pkg::ATTR_FIELD_MASK) == tcpg_pkg::ATTR_REVERSE) begin
            n_dec.fg = 4'd0;
            n_dec.bg = tcpg_pkg::FG_NORMAL;
        end
        if (attr[3]) begin
            n_dec.fg[3] = 1'b1;
        end
        if (attr[7]) begin
            n_dec.bg[3] = 1'b1;
        end
        if ((attr & tcpg_pkg::ATTR_FIELD_MASK) == 8'h00) begin
            n_dec.fg = n_dec.bg;
        end
        n_dec.underline  = (attr[2:0] == tcpg_pkg::ATTR_UNDERLINE) &&
                           (i_cell.scan_line == tcpg_pkg::UNDERLINE_LINE);
        n_dec.line_gfx   = !i_cfg.narrow_cells &&
                           (i_cell.char_code[7:5] == tcpg_pkg::LINE_GFX_TOP);
        n_dec.cursor     = i_cell.cursor_here;
        n_dec.cursor_col = tcpg_pkg::cursor_colour(i_cell.attribute);
        n_dec.glyph      = i_cell.glyph_row;
        n_dec.narrow     = i_cfg.narrow_cells;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dec <= n_dec;
        end
    end

    assign o_dec = r_dec;

endmodule

`default_nettype wire

[hdl/tcpg_bits.sv]
// Second stage: foreground mask of the cell row from glyph, underline and blink.
`timescale 1ns / 1ps
`default_nettype none

module tcpg_bits (
    input  wire              i_clk,
    input  wire              i_load,
    input  tcpg_pkg::t_dec   i_dec,
    output tcpg_pkg::t_row   o_row
);

    tcpg_pkg::t_row r_row;
    tcpg_pkg::t_row n_row;

    always_comb begin
        n_row.fg         = i_dec.fg;
        n_row.bg         = i_dec.bg;
        n_row.cursor     = i_dec.cursor;
        n_row.cursor_col = i_dec.cursor_col;
        n_row.narrow     = i_dec.narrow;
        n_row.font       = i_dec.font;
        priority if (i_dec.blank) begin
            n_row.bits = 9'h000;
        end else if (i_dec.underline) begin
            n_row.bits = 9'h1FF;
        end else begin
            n_row.bits = {i_dec.glyph, i_dec.line_gfx & i_dec.glyph[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

`default_nettype wire

[hdl/tcpg_expand.sv]
// Third stage: expansion of the row mask into nine colour codes.
`timescale 1ns / 1ps
`default_nettype none

module tcpg_expand (
    input  wire              i_clk,
    input  wire              i_load,
    input  tcpg_pkg::t_row   i_row,
    output tcpg_pkg::t_out   o_res
);

    tcpg_pkg::t_out r_res;
    tcpg_pkg::t_out n_res;
    logic [4:0]     code;

    always_comb begin
        n_res = '0;
        code  = '0;
        for (int i = 0; i < tcpg_pkg::PIX_COUNT; i++) begin
            if (i_row.cursor) begin
                code = i_row.cursor_col;
            end else if (i_row.bits[tcpg_pkg::PIX_COUNT - 1 - i]) begin
                code = {1'b0, i_row.fg};
            end else begin
                code = {1'b0, i_row.bg};
            end
            if (i == tcpg_pkg::PIX_COUNT - 1 && i_row.narrow) begin
                code = '0;
            end
            n_res.pixel_codes[i * tcpg_pkg::PIX_BITS +: tcpg_pkg::PIX_BITS] = code;
        end
        n_res.cell_width  = i_row.narrow ? tcpg_pkg::CELL_NARROW : tcpg_pkg::CELL_WIDE;
        n_res.font_number = i_row.font;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[hdl/text_cell_pixel_generator.sv]
// Top level of the text cell pixel generator: configuration, pipeline control and stages.
// The input channel takes one text cell for one scan line per transfer: character code,
// attribute byte, the glyph row already fetched, scan line, blink phase and cursor flag.
// The output channel gives one transfer per cell: nine 5-bit colour codes, the cell width
// (8 or 9) and the font number selected in 48k RAM-font mode.
// Both channels use valid and stall; a transfer completes when valid is high and stall low.
// The pipeline has three register stages (decode, row mask, pixel expansion), and a result
// is registered in each of them in turn before it is presented; one cell is taken every
// cycle while the receiver does not stall.
// A stall from the receiver holds the output stage; earlier stages keep filling until they
// are full, and only then is the input stalled. Nothing is dropped or repeated.
// The registers font_source, narrow_cells and blink_enable sit at byte addresses 0, 4, 8
// of the APB port; the user must write them only while the pipeline is empty (not enforced).
// Reset clears the registers and all stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module text_cell_pixel_generator (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  tcpg_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output tcpg_pkg::t_out                      o_out_data,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [tcpg_pkg::PADDR_BITS-1:0]     paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    tcpg_pkg::t_cfg r_cfg;
    tcpg_pkg::t_dec dec;
    tcpg_pkg::t_row row;
    logic           r_v1;
    logic           r_v2;
    logic           r_v3;
    logic           rdy1;
    logic           rdy2;
    logic           rdy3;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                tcpg_pkg::REG_FONT_SOURCE:  r_cfg.font_source  <= pwdata[1:0];
                tcpg_pkg::REG_NARROW_CELLS: r_cfg.narrow_cells <= pwdata[0];
                tcpg_pkg::REG_BLINK_ENABLE: r_cfg.blink_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tcpg_pkg::REG_FONT_SOURCE:  prdata = {30'd0, r_cfg.font_source};
            tcpg_pkg::REG_NARROW_CELLS: prdata = {31'd0, r_cfg.narrow_cells};
            tcpg_pkg::REG_BLINK_ENABLE: prdata = {31'd0, r_cfg.blink_enable};
            default:                    prdata = 32'd0;
        endcase
    end

    assign rdy3       = !r_v3 || !i_out_stall;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    tcpg_decode u_decode (
        .i_clk  (i_clk),
        .i_load (rdy1 && i_in_valid),
        .i_cell (i_in_data),
        .i_cfg  (r_cfg),
        .o_dec  (dec)
    );

    tcpg_bits u_bits (
        .i_clk  (i_clk),
        .i_load (rdy2 && r_v1),
        .i_dec  (dec),
        .o_row  (row)
    );

    tcpg_expand u_expand (
        .i_clk  (i_clk),
        .i_load (rdy3 && r_v2),
        .i_row  (row),
        .o_res  (o_out_data)
    );

    assign o_out_valid = r_v3;

    a_width_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cell_width == tcpg_pkg::CELL_NARROW ||
                         o_out_data.cell_width == tcpg_pkg::CELL_WIDE))
        else $error("Cell width is neither eight nor nine.");

    a_narrow_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.cell_width == tcpg_pkg::CELL_NARROW) |->
        (o_out_data.pixel_codes[44:40] == 5'd0))
        else $error("Ninth pixel of an eight-pixel cell is not zero.");

    a_font_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.font_number <= tcpg_pkg::MAX_FONT))
        else $error("Font number out of range.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && i_out_stall))
        else $error("Input stalled while the pipeline has room.");

endmodule

`default_nettype wire

[dv/tb_text_cell_pixel_generator.sv]
// Self-checking testbench for the text cell pixel generator, with its own model of the cell decode.
`timescale 1ns / 1ps

module tb_text_cell_pixel_generator;
    import tcpg_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_CELLS    = 120;
    localparam int REPORT_LIMIT   = 10;
    localparam int SETTLE_CYCLES  = 10;
    localparam logic [127:0] NOTABLE_ATTRS = {
        8'h00, 8'h08, 8'h80, 8'h88, 8'h70, 8'hF0, 8'h78, 8'hF8,
        8'h01, 8'h09, 8'h81, 8'h89, 8'h07, 8'h0F, 8'h77, 8'hFF
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    t_in                   in_data = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    t_out                  o_out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_BITS-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    logic [1:0] cfg_font = FONT_ROM;
    logic       cfg_narrow = 1'b0;
    logic       cfg_blink = 1'b0;

    t_in  cell_queue[$];
    t_out row_queue[$];
    int   queued_cells = 0;
    int   checked_rows = 0;
    int   error_count = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    text_cell_pixel_generator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out expected_row(input t_in src);
        logic [7:0] attr;
        logic [3:0] font;
        logic [3:0] fg;
        logic [3:0] bg;
        logic [8:0] bits;
        logic [4:0] cursor_code;
        logic [4:0] code;
        logic       blanked;
        logic       underline;
        logic       graphic;
        t_out       row;
        int         k;
        begin
            attr = src.attribute;
            font = 4'd0;
            blanked = 1'b0;
            if (cfg_font == FONT_RAM48K) begin
                font = src.attribute[3:0];
                if (font > MAX_FONT) begin
                    font = {1'b0, font[2:0]};
                end
                attr = {4'h0, src.attribute[7:4] ^ 4'hF};
            end
            if (cfg_blink) begin
                blanked = attr[7] & src.blink_phase;
                attr[7] = 1'b0;
            end
            fg = FG_NORMAL;
            bg = 4'd0;
            if ((attr & ATTR_FIELD_MASK) == ATTR_REVERSE) begin
                fg = 4'd0;
                bg = FG_NORMAL;
            end
            if (attr[3]) begin
                fg[3] = 1'b1;
            end
            if (attr[7]) begin
                bg[3] = 1'b1;
            end
            if ((attr & ATTR_FIELD_MASK) == 8'h00) begin
                fg = bg;
            end
            underline = (attr[2:0] == ATTR_UNDERLINE) && (src.scan_line == UNDERLINE_LINE);
            graphic = !cfg_narrow && (src.char_code[7:5] == LINE_GFX_TOP);

            if (blanked) begin
                bits = '0;
            end else if (underline) begin
                bits = '1;
            end else begin
                bits = {src.glyph_row, 1'b0};
                if (graphic) begin
                    bits[0] = src.glyph_row[0];
                end
            end

            case (src.attribute)
                8'h70, 8'hF0, 8'h00, 8'h08, 8'h80, 8'h88: begin
                    cursor_code = CURSOR_BLACK;
                end
                8'h78, 8'hF8: begin
                    cursor_code = CURSOR_NORMAL;
                end
                default: begin
                    cursor_code = src.attribute[3] ? CURSOR_BRIGHT : CURSOR_NORMAL;
                end
            endcase

            row.pixel_codes = '0;
            row.cell_width = cfg_narrow ? CELL_NARROW : CELL_WIDE;
            row.font_number = font;
            for (k = 0; k < PIX_COUNT; k++) begin
                if (k < row.cell_width) begin
                    if (src.cursor_here) begin
                        code = cursor_code;
                    end else begin
                        code = bits[8-k] ? {1'b0, fg} : {1'b0, bg};
                    end
                    row.pixel_codes[PIX_BITS*k +: PIX_BITS] = code;
                end
            end
            return row;
        end
    endfunction

    task automatic note_error(input string msg);
        begin
            if (error_count < REPORT_LIMIT) begin
                $display("ERROR at cycle %0d: %s", cycle_count, msg);
            end
            error_count++;
        end
    endtask

    // Cell driver: a held transfer keeps its payload until the block takes it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                row_queue.push_back(expected_row(in_data));
            end
            if (!in_valid || !o_in_stall) begin
                if (cell_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= cell_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Row monitor and receiver back-pressure.
    always @(posedge i_clk) begin : row_monitor
        t_out want;
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (row_queue.size() == 0) begin
                note_error($sformatf("unexpected row %h", o_out_data));
            end else begin
                want = row_queue.pop_front();
                checked_rows++;
                if (o_out_data.pixel_codes !== want.pixel_codes ||
                    o_out_data.cell_width !== want.cell_width ||
                    o_out_data.font_number !== want.font_number) begin
                    note_error($sformatf(
                        "pixels exp %h got %h, width exp %0d got %0d, font exp %0d got %0d",
                        want.pixel_codes, o_out_data.pixel_codes,
                        want.cell_width, o_out_data.cell_width,
                        want.font_number, o_out_data.font_number));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_cell(input logic [7:0] chr, input logic [7:0] attr,
                            input logic [7:0] glyph, input logic [4:0] line,
                            input logic phase, input logic cursor);
        t_in entry;
        begin
            entry.char_code = chr;
            entry.attribute = attr;
            entry.glyph_row = glyph;
            entry.scan_line = line;
            entry.blink_phase = phase;
            entry.cursor_here = cursor;
            cell_queue.push_back(entry);
            queued_cells++;
        end
    endtask

    task automatic wait_drained();
        begin
            while (checked_rows != queued_cells) begin
                @(posedge i_clk);
            end
        end
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        begin
            @(posedge i_clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {index, 2'b00};
            pwdata <= value;
            @(posedge i_clk);
            penable <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!pready);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
    endtask

    task automatic set_config(input logic [1:0] font, input logic narrow, input logic blink);
        begin
            wait_drained();
            apb_write(REG_FONT_SOURCE, {30'd0, font});
            cfg_font = font;
            apb_write(REG_NARROW_CELLS, {31'd0, narrow});
            cfg_narrow = narrow;
            apb_write(REG_BLINK_ENABLE, {31'd0, blink});
            cfg_blink = blink;
        end
    endtask

    initial begin
        int         ph;
        int         n;
        logic [7:0] chr;
        logic [7:0] attr;
        logic [4:0] line;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(FONT_ROM, 1'b0, 1'b0);
        add_cell(8'h00, 8'h00, 8'h00, 5'd0, 1'b0, 1'b0);
        add_cell(8'hFF, 8'hFF, 8'hFF, 5'd31, 1'b1, 1'b1);
        add_cell(8'h41, 8'h07, 8'hA5, 5'd3, 1'b0, 1'b0);
        add_cell(8'h41, 8'h70, 8'h3C, 5'd5, 1'b0, 1'b0);
        add_cell(8'h41, 8'h01, 8'h00, UNDERLINE_LINE, 1'b0, 1'b0);
        add_cell(8'h41, 8'h09, 8'h81, 5'd12, 1'b0, 1'b0);
        add_cell(8'h41, 8'h00, 8'hFF, 5'd2, 1'b0, 1'b0);
        add_cell(8'h41, 8'h88, 8'hFF, 5'd2, 1'b0, 1'b0);
        add_cell(8'hC0, 8'h07, 8'h01, 5'd4, 1'b0, 1'b0);
        add_cell(8'hDF, 8'h0F, 8'hFF, 5'd4, 1'b0, 1'b0);
        add_cell(8'hBF, 8'h07, 8'h01, 5'd4, 1'b0, 1'b0);
        add_cell(8'hE0, 8'h07, 8'h01, 5'd4, 1'b0, 1'b0);
        add_cell(8'h41, 8'h78, 8'h55, 5'd1, 1'b0, 1'b1);
        add_cell(8'h41, 8'h0F, 8'h55, 5'd1, 1'b0, 1'b1);
        add_cell(8'h41, 8'h70, 8'h55, 5'd1, 1'b0, 1'b1);

        // Narrow cells with blink: a blinking underline shows background only.
        set_config(FONT_ROM, 1'b1, 1'b1);
        add_cell(8'hC0, 8'h81, 8'h01, UNDERLINE_LINE, 1'b1, 1'b0);
        add_cell(8'hC0, 8'h81, 8'h01, UNDERLINE_LINE, 1'b0, 1'b0);
        add_cell(8'h41, 8'hF0, 8'hAA, 5'd7, 1'b1, 1'b0);

        // The 48k font mode folds high font numbers and inverts the attribute nibble.
        set_config(FONT_RAM48K, 1'b0, 1'b1);
        add_cell(8'h41, 8'h0C, 8'hAA, UNDERLINE_LINE, 1'b1, 1'b0);
        add_cell(8'h41, 8'hFF, 8'hAA, UNDERLINE_LINE, 1'b1, 1'b0);
        add_cell(8'h41, 8'hEB, 8'hAA, UNDERLINE_LINE, 1'b1, 1'b0);
        add_cell(8'h41, 8'h80, 8'hAA, 5'd3, 1'b1, 1'b1);

        set_config(2'd3, 1'b0, 1'b0);
        add_cell(8'h41, 8'h3F, 8'hAA, 5'd3, 1'b0, 1'b0);

        for (ph = 0; ph < 16; ph++) begin
            set_config(ph[1:0], ph[2], ph[3]);
            case ((ph + ph / 4) % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 71;
                end
                default: begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                end
            endcase
            for (n = 0; n < PHASE_CELLS; n++) begin
                chr = ($urandom_range(3) == 0) ? (8'hC0 | 8'($urandom_range(31)))
                                               : 8'($urandom_range(255));
                attr = ($urandom_range(2) == 0) ? NOTABLE_ATTRS[8*$urandom_range(15) +: 8]
                                                : 8'($urandom_range(255));
                line = ($urandom_range(3) == 0) ? UNDERLINE_LINE : 5'($urandom_range(31));
                add_cell(chr, attr, 8'($urandom_range(255)), line,
                         1'($urandom_range(1)), $urandom_range(7) == 0);
                if (ph % 3 == 0 && n == PHASE_CELLS / 2) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (row_queue.size() != 0) begin
            note_error($sformatf("%0d expected rows never arrived", row_queue.size()));
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
